// ===== rtl/neighbor_contrast_pixel_count_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the neighbor contrast pixel count core
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef NEIGHBOR_CONTRAST_PIXEL_COUNT_CORE_DEFINES_SVH
`define NEIGHBOR_CONTRAST_PIXEL_COUNT_CORE_DEFINES_SVH

`ifndef SYNTH
`define NCPC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ncpc assertion failed");
`define NCPC_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("ncpc assertion failed");
`else
`define NCPC_ASSERT(label, clk, rst, prop)
`define NCPC_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== rtl/ncpc_pkg.sv =====
// ----------------------------------------------------------------------------
// ncpc_pkg
// Shared widths, register indexes and helper functions of the contrast counter.
// ----------------------------------------------------------------------------
package ncpc_pkg;

   localparam int PIXEL_W       = 8;
   localparam int COUNT_W       = 18;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 10;
   localparam int FRAME_WIDTH_W = 10;
   localparam int FRAME_HEIGHT_W = 9;

   localparam int DEFAULT_MAX_WIDTH  = 512;
   localparam int DEFAULT_MAX_HEIGHT = 256;

   localparam int RESET_FRAME_WIDTH  = 320;
   localparam int RESET_FRAME_HEIGHT = 200;
   localparam logic [PIXEL_W-1:0] RESET_THRESHOLD = 8'd128;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH        = 2'd0,
      CSR_FRAME_HEIGHT       = 2'd1,
      CSR_CONTRAST_THRESHOLD = 2'd2
   } csr_index_type;

   function automatic logic differs(input logic [PIXEL_W-1:0] a,
                                    input logic [PIXEL_W-1:0] b,
                                    input logic [PIXEL_W-1:0] thr);
      logic [PIXEL_W-1:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return d > thr;
   endfunction

   // Clamps a dimension to 2..hi and returns the index of its last element.
   function automatic logic [15:0] clamp_last(input logic [15:0] v,
                                              input logic [15:0] hi);
      logic [15:0] r;
      if (v < 16'd2) begin
         r = 16'd1;
      end else if (v > hi) begin
         r = hi - 16'd1;
      end else begin
         r = v - 16'd1;
      end
      return r;
   endfunction

endpackage

// ===== rtl/ncpc_if.sv =====
// ----------------------------------------------------------------------------
// ncpc channel interfaces
// Valid/ready channels for pixels, frame counts and register writes.
// ----------------------------------------------------------------------------
interface ncpc_req_if;
   import ncpc_pkg::*;
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel_value;
   modport source (output valid, output pixel_value, input ready);
   modport sink   (input valid, input pixel_value, output ready);
endinterface

interface ncpc_rsp_if;
   import ncpc_pkg::*;
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] contrast_count;
   modport source (output valid, output contrast_count, input ready);
   modport sink   (input valid, input contrast_count, output ready);
endinterface

interface ncpc_csr_if;
   import ncpc_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  wdata;
   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/ncpc_ram.sv =====
// ----------------------------------------------------------------------------
// ncpc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ncpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/neighbor_contrast_pixel_count_core.sv =====
// ----------------------------------------------------------------------------
// neighbor_contrast_pixel_count_core
// Counts pixels of a raster frame that differ from a 4-neighbor by more than
// a threshold, and reports the count once per frame.
// ----------------------------------------------------------------------------
// Usage:
// Pixels enter on req_if in raster order, one item per accepted handshake.
// One pixel is taken every clock cycle unless req_if is held off; the count
// of a frame leaves on rsp_if in the cycle after its last pixel is taken.
// The previous row is held in two registered-read RAMs (pixels and contrast
// flags), each read one column ahead and written at most once per pixel, so
// the single RAM write port per memory sets the rate of one pixel per cycle.
// The result sits in an output register. While a count waits on a stalled
// receiver, pixels keep flowing until the last pixel of the next frame, which
// is held off until the waiting count is taken.
// csr_if writes frame_width (0), frame_height (1) and contrast_threshold (2);
// it is always ready, and req_if is held off while a write is offered. A
// geometry write restarts the frame without a result.
// Reset restores 320 x 200 with threshold 128 and starts a new frame. The
// RAMs need no clearing pass: only entries of the current frame are read.
// ----------------------------------------------------------------------------
`include "neighbor_contrast_pixel_count_core_defines.svh"

module neighbor_contrast_pixel_count_core #(
   parameter int MAX_WIDTH  = ncpc_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = ncpc_pkg::DEFAULT_MAX_HEIGHT
) (
   input  logic       clock,
   input  logic       reset,
   ncpc_req_if.sink   req_if,
   ncpc_rsp_if.source rsp_if,
   ncpc_csr_if.sink   csr_if
);

   import ncpc_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int RESET_W = (RESET_FRAME_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_FRAME_WIDTH;
   localparam int RESET_H = (RESET_FRAME_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT
                                                             : RESET_FRAME_HEIGHT;
   localparam logic [CW-1:0] WIDTH_LAST_RESET  = CW'(RESET_W - 1);
   localparam logic [RW-1:0] HEIGHT_LAST_RESET = RW'(RESET_H - 1);

   logic [CW-1:0]      width_last_ff, width_last_in;
   logic [RW-1:0]      height_last_ff, height_last_in;
   logic [PIXEL_W-1:0] thresh_ff, thresh_in;

   logic [CW-1:0]      col_ff, col_in;
   logic [RW-1:0]      row_ff, row_in;
   logic [PIXEL_W-1:0] left_pix_ff, left_pix_in;
   logic               left_flag_ff, left_flag_in;
   logic               end_flag_ff, end_flag_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic               fwd_hit_ff, fwd_hit_in;
   logic               fwd_flag_ff, fwd_flag_in;

   logic               csr_wr, accept, step;
   logic [PIXEL_W-1:0] pix;
   logic [PIXEL_W-1:0] above_pix;
   logic               above_flag_ram, above_flag;
   logic               first_col, last_col, first_row, last_row, last_pixel;
   logic               diff_left, diff_up, cur, left_final;
   logic               inc_above, inc_left, inc_self;
   logic               flag_we;
   logic [CW-1:0]      flag_waddr;

   assign csr_wr        = csr_if.valid && csr_if.ready;
   assign csr_if.ready  = 1'b1;
   assign req_if.ready  = !csr_if.valid && (!rsp_valid_ff || rsp_if.ready || !last_pixel);
   assign accept        = req_if.valid && req_if.ready;
   assign step          = accept && !csr_wr;
   assign pix           = req_if.pixel_value;

   assign first_col  = (col_ff == '0);
   assign last_col   = (col_ff == width_last_ff);
   assign first_row  = (row_ff == '0);
   assign last_row   = (row_ff == height_last_ff);
   assign last_pixel = last_col && last_row;

   assign above_flag = last_col ? end_flag_ff : (fwd_hit_ff ? fwd_flag_ff : above_flag_ram);

   assign diff_left  = !first_col && differs(pix, left_pix_ff, thresh_ff);
   assign diff_up    = !first_row && differs(pix, above_pix, thresh_ff);
   assign cur        = diff_left || diff_up;
   assign left_final = left_flag_ff || diff_left;

   assign inc_above = !first_row && (diff_up || above_flag);
   assign inc_left  = last_row && !first_col && left_final;
   assign inc_self  = last_row && last_col && cur;

   assign flag_we    = step && !first_col;
   assign flag_waddr = col_ff - CW'(1);

   always_comb begin
      width_last_in  = width_last_ff;
      height_last_in = height_last_ff;
      thresh_in      = thresh_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      left_pix_in    = left_pix_ff;
      left_flag_in   = left_flag_ff;
      end_flag_in    = end_flag_ff;
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_count_in   = rsp_count_ff;

      if (csr_wr) begin
         unique case (csr_if.index)
            CSR_FRAME_WIDTH: begin
               width_last_in = CW'(clamp_last(16'(csr_if.wdata[FRAME_WIDTH_W-1:0]),
                                              16'(MAX_WIDTH)));
               col_in        = '0;
               row_in        = '0;
               left_pix_in   = '0;
               count_in      = '0;
            end
            CSR_FRAME_HEIGHT: begin
               height_last_in = RW'(clamp_last(16'(csr_if.wdata[FRAME_HEIGHT_W-1:0]),
                                               16'(MAX_HEIGHT)));
               col_in         = '0;
               row_in         = '0;
               left_pix_in    = '0;
               count_in       = '0;
            end
            CSR_CONTRAST_THRESHOLD: begin
               thresh_in = csr_if.wdata[PIXEL_W-1:0];
            end
            default: begin
            end
         endcase
      end else if (step) begin
         left_pix_in  = pix;
         left_flag_in = cur;
         if (last_col) begin
            end_flag_in = cur;
         end
         count_in = count_ff + COUNT_W'(inc_above) + COUNT_W'(inc_left)
                    + COUNT_W'(inc_self);
         if (last_col) begin
            col_in = '0;
            if (last_row) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = count_in;
               count_in     = '0;
               row_in       = '0;
            end else begin
               row_in = row_ff + RW'(1);
            end
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   assign fwd_hit_in  = flag_we && (flag_waddr == col_in);
   assign fwd_flag_in = left_final;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_last_ff  <= WIDTH_LAST_RESET;
         height_last_ff <= HEIGHT_LAST_RESET;
         thresh_ff      <= RESET_THRESHOLD;
         col_ff         <= '0;
         row_ff         <= '0;
         left_pix_ff    <= '0;
         left_flag_ff   <= 1'b0;
         end_flag_ff    <= 1'b0;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         fwd_hit_ff     <= 1'b0;
      end else begin
         width_last_ff  <= width_last_in;
         height_last_ff <= height_last_in;
         thresh_ff      <= thresh_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         left_pix_ff    <= left_pix_in;
         left_flag_ff   <= left_flag_in;
         end_flag_ff    <= end_flag_in;
         count_ff       <= count_in;
         rsp_valid_ff   <= rsp_valid_in;
         fwd_hit_ff     <= fwd_hit_in;
      end
      rsp_count_ff <= rsp_count_in;
      fwd_flag_ff  <= fwd_flag_in;
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.contrast_count = rsp_count_ff;

   ncpc_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_pixel_ram (
      .clock   (clock),
      .wr_en   (step),
      .wr_addr (col_ff),
      .wr_data (pix),
      .rd_addr (col_in),
      .rd_data (above_pix)
   );

   ncpc_ram #(
      .WIDTH (1),
      .DEPTH (MAX_WIDTH)
   ) u_flag_ram (
      .clock   (clock),
      .wr_en   (flag_we),
      .wr_addr (flag_waddr),
      .wr_data (left_final),
      .rd_addr (col_in),
      .rd_data (above_flag_ram)
   );

   `NCPC_ASSERT(a_col_in_frame, clock, reset, col_ff <= width_last_ff)
   `NCPC_ASSERT(a_row_in_frame, clock, reset, row_ff <= height_last_ff)
   `NCPC_ASSERT(a_result_after_last, clock, reset,
                step && last_pixel |=> rsp_valid_ff && count_ff == '0)
   `NCPC_ASSERT(a_fwd_narrow_only, clock, reset, fwd_hit_ff |-> width_last_ff == CW'(1))
   `NCPC_ASSERT(a_no_load_when_full, clock, reset,
                rsp_valid_ff && !rsp_if.ready |=> $stable(rsp_count_ff))

endmodule
